// ----- rtl/pla_pkg.sv -----
`default_nettype none
package pla_pkg;

  // data path format, signed Q(DATA_WIDTH-FRAC_BITS).FRAC_BITS
  localparam int DATA_WIDTH  = 16;
  localparam int FRAC_BITS   = 8;

  // slope format, signed Q8.16
  localparam int SLOPE_WIDTH = 24;
  localparam int SLOPE_FRAC  = 16;

  localparam int MODE_WIDTH  = 3;

  // configuration port
  localparam int APB_DATA_WIDTH = 32;
  localparam int NUM_REGS       = 4;
  localparam int REG_IDX_WIDTH  = $clog2(NUM_REGS);
  localparam int APB_ADDR_WIDTH = REG_IDX_WIDTH + 2;

  // leaky relu slope 0.01 in Q8.16
  localparam logic signed [SLOPE_WIDTH-1:0] LEAKY_SLOPE = SLOPE_WIDTH'(655);

  typedef enum logic [MODE_WIDTH-1:0] {
    MODE_LINEAR = 3'd0,
    MODE_CLIP   = 3'd1,
    MODE_RELU   = 3'd2,
    MODE_LEAKY  = 3'd3,
    MODE_PRELU  = 3'd4
  } mode_t;

  typedef enum logic [REG_IDX_WIDTH-1:0] {
    REG_MODE      = 2'd0,
    REG_CLIP_LOW  = 2'd1,
    REG_CLIP_HIGH = 2'd2,
    REG_NEG_SLOPE = 2'd3
  } reg_idx_t;

  localparam logic [MODE_WIDTH-1:0] MODE_RESET = MODE_RELU;
  localparam logic signed [DATA_WIDTH-1:0] CLIP_LOW_RESET  = -DATA_WIDTH'(1 << FRAC_BITS);
  localparam logic signed [DATA_WIDTH-1:0] CLIP_HIGH_RESET = DATA_WIDTH'(1 << FRAC_BITS);
  localparam logic signed [SLOPE_WIDTH-1:0] NEG_SLOPE_RESET = LEAKY_SLOPE;

  typedef struct packed {
    logic [MODE_WIDTH-1:0]          mode;
    logic signed [DATA_WIDTH-1:0]   clip_low;
    logic signed [DATA_WIDTH-1:0]   clip_high;
    logic signed [SLOPE_WIDTH-1:0]  neg_slope;
  } cfg_t;

endpackage
`default_nettype wire

// ----- rtl/pla_if.sv -----
`default_nettype none
// input channel: one sample per request
interface pla_in_if;
  import pla_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// result channel: activation and derivative per request
interface pla_out_if;
  import pla_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] activation;
  logic signed [DATA_WIDTH-1:0] derivative;

  modport source (output valid, output activation, output derivative, input ready);
  modport sink   (input valid, input activation, input derivative, output ready);
endinterface
`default_nettype wire

// ----- rtl/pla_core.sv -----
`default_nettype none
module pla_core (
  input  pla_pkg::cfg_t                        cfg,
  input  logic signed [pla_pkg::DATA_WIDTH-1:0] sample,
  output logic signed [pla_pkg::DATA_WIDTH-1:0] activation,
  output logic signed [pla_pkg::DATA_WIDTH-1:0] derivative
);
  import pla_pkg::*;

  localparam int ProdW  = DATA_WIDTH + SLOPE_WIDTH;
  localparam int ShW    = ProdW - SLOPE_FRAC;
  localparam int DerShW = SLOPE_WIDTH - (SLOPE_FRAC - FRAC_BITS);
  localparam int DerW   = (DerShW > DATA_WIDTH) ? DerShW : DATA_WIDTH;

  localparam logic signed [DATA_WIDTH-1:0] OneVal = DATA_WIDTH'(1 << FRAC_BITS);
  localparam logic signed [DATA_WIDTH-1:0] MaxVal = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] MinVal = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  logic                          sloped;
  logic signed [SLOPE_WIDTH-1:0] slope;
  logic signed [ProdW-1:0]       prod;
  logic signed [ShW-1:0]         prod_sh;
  logic signed [DerShW-1:0]      der_sh;
  logic signed [DerW-1:0]        der_ext;
  logic signed [DATA_WIDTH-1:0]  prod_sat;
  logic signed [DATA_WIDTH-1:0]  der_sat;
  logic                          neg;

  assign neg = sample[DATA_WIDTH-1];

  always_comb begin
    sloped = 1'b0;
    slope  = LEAKY_SLOPE;
    case (cfg.mode)
      MODE_LEAKY: begin
        sloped = 1'b1;
        slope  = LEAKY_SLOPE;
      end
      MODE_PRELU: begin
        sloped = 1'b1;
        slope  = cfg.neg_slope;
      end
      default: begin
        sloped = 1'b0;
        slope  = LEAKY_SLOPE;
      end
    endcase
  end

  // floor shift by part-select, then clamp if the top bits disagree with the sign
  assign prod    = ProdW'(sample) * ProdW'(slope);
  assign prod_sh = $signed(prod[ProdW-1:SLOPE_FRAC]);
  assign der_sh  = $signed(slope[SLOPE_WIDTH-1:SLOPE_FRAC-FRAC_BITS]);
  assign der_ext = DerW'(der_sh);

  always_comb begin
    if (prod_sh[ShW-1:DATA_WIDTH-1] == '0 || prod_sh[ShW-1:DATA_WIDTH-1] == '1) begin
      prod_sat = prod_sh[DATA_WIDTH-1:0];
    end else begin
      prod_sat = prod_sh[ShW-1] ? MinVal : MaxVal;
    end
    if (der_ext[DerW-1:DATA_WIDTH-1] == '0 || der_ext[DerW-1:DATA_WIDTH-1] == '1) begin
      der_sat = der_ext[DATA_WIDTH-1:0];
    end else begin
      der_sat = der_ext[DerW-1] ? MinVal : MaxVal;
    end
  end

  always_comb begin
    activation = sample;
    derivative = OneVal;
    case (cfg.mode)
      MODE_CLIP: begin
        if (sample > cfg.clip_high) begin
          activation = cfg.clip_high;
        end else if (sample < cfg.clip_low) begin
          activation = cfg.clip_low;
        end
        if (sample < cfg.clip_low || sample > cfg.clip_high) begin
          derivative = '0;
        end
      end
      MODE_RELU: begin
        if (neg) begin
          activation = '0;
          derivative = '0;
        end
      end
      default: begin
        activation = sample;
        derivative = OneVal;
      end
    endcase
    if (sloped && neg) begin
      activation = prod_sat;
      derivative = der_sat;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/piecewise_linear_activation_top.sv -----
`default_nettype none
// piecewise-linear activation unit (linear, clipped linear, relu, leaky relu, prelu)
//
// in_chan carries one signed Q8.8 sample per request; out_chan returns the
// activation and its derivative, both signed Q8.8, one result per request and
// in request order. both channels use valid/ready, a request moves at a clock
// edge with valid and ready high.
// a sample accepted into the input register passes on to the result register,
// and out_chan shows its result from there.
// throughput: one request per cycle while out_chan is not stalled, set by the
// two-register pipeline (input register, then result register); one 16x24
// multiply lies between them. when the receiver stalls, the result register
// holds its value and the input register keeps taking a request until it is
// full; in_chan.ready then follows out_chan.ready.
// the apb port (psel ... prdata) holds mode, clip_low, clip_high and neg_slope
// at byte addresses 0, 4, 8, 12; pready is tied high. write it only when idle.
// synchronous active-low reset empties the pipeline and loads mode relu,
// clip limits -1.0 and +1.0, and slope 0.01.
module piecewise_linear_activation_top (
  input  logic                                clk,
  input  logic                                rst_n,
  pla_in_if.sink                              in_chan,
  pla_out_if.source                           out_chan,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [pla_pkg::APB_ADDR_WIDTH-1:0]  paddr,
  input  logic [pla_pkg::APB_DATA_WIDTH-1:0]  pwdata,
  output logic [pla_pkg::APB_DATA_WIDTH-1:0]  prdata,
  output logic                                pready
);
  import pla_pkg::*;

  // configuration registers
  cfg_t                         cfg_r;
  logic                         cfg_wr;
  logic [REG_IDX_WIDTH-1:0]     reg_idx;

  // pipeline
  logic                         s1_valid_r;
  logic                         s1_valid_nxt;
  logic signed [DATA_WIDTH-1:0] s1_sample_r;
  logic                         res_valid_r;
  logic                         res_valid_nxt;
  logic signed [DATA_WIDTH-1:0] res_act_r;
  logic signed [DATA_WIDTH-1:0] res_der_r;
  logic                         res_adv;
  logic                         s1_adv;
  logic signed [DATA_WIDTH-1:0] core_act;
  logic signed [DATA_WIDTH-1:0] core_der;

  // apb: word index from the byte address, no wait states
  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_WIDTH-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode      <= MODE_RESET;
      cfg_r.clip_low  <= CLIP_LOW_RESET;
      cfg_r.clip_high <= CLIP_HIGH_RESET;
      cfg_r.neg_slope <= NEG_SLOPE_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_MODE:      cfg_r.mode      <= pwdata[MODE_WIDTH-1:0];
        REG_CLIP_LOW:  cfg_r.clip_low  <= pwdata[DATA_WIDTH-1:0];
        REG_CLIP_HIGH: cfg_r.clip_high <= pwdata[DATA_WIDTH-1:0];
        REG_NEG_SLOPE: cfg_r.neg_slope <= pwdata[SLOPE_WIDTH-1:0];
        default: begin
        end
      endcase
    end
  end

  // read back, zero-extended to the bus width
  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_MODE:      prdata = APB_DATA_WIDTH'(cfg_r.mode);
      REG_CLIP_LOW:  prdata = APB_DATA_WIDTH'($unsigned(cfg_r.clip_low));
      REG_CLIP_HIGH: prdata = APB_DATA_WIDTH'($unsigned(cfg_r.clip_high));
      REG_NEG_SLOPE: prdata = APB_DATA_WIDTH'($unsigned(cfg_r.neg_slope));
      default:       prdata = '0;
    endcase
  end

  // each stage moves when the one after it is empty or moving
  assign res_adv       = !res_valid_r || out_chan.ready;
  assign s1_adv        = !s1_valid_r || res_adv;
  assign in_chan.ready = s1_adv;

  always_comb begin
    s1_valid_nxt  = s1_adv ? in_chan.valid : s1_valid_r;
    res_valid_nxt = res_adv ? s1_valid_r : res_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (s1_adv && in_chan.valid) begin
      s1_sample_r <= in_chan.sample;
    end
  end

  pla_core u_core (
    .cfg        (cfg_r),
    .sample     (s1_sample_r),
    .activation (core_act),
    .derivative (core_der)
  );

  // result register, held while the receiver stalls
  always_ff @(posedge clk) begin
    if (res_adv && s1_valid_r) begin
      res_act_r <= core_act;
      res_der_r <= core_der;
    end
  end

  assign out_chan.valid      = res_valid_r;
  assign out_chan.activation = res_act_r;
  assign out_chan.derivative = res_der_r;

endmodule
`default_nettype wire

// ----- rtl/pla_checker.sv -----
`default_nettype none
module pla_checker (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  input  logic                                  in_ready,
  input  logic                                  out_valid,
  input  logic                                  out_ready,
  input  logic signed [pla_pkg::DATA_WIDTH-1:0] out_activation,
  input  logic signed [pla_pkg::DATA_WIDTH-1:0] out_derivative
);
  import pla_pkg::*;

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_activation)
                                && $stable(out_derivative))
    else $error("stalled result changed");

  // an accepted sample shows up once it has passed the input and result registers
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> ##2 out_valid)
    else $error("result missing after accepted request");

  // no result appears without an earlier accepted request
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_acc, 2))
    else $error("result without request");

  // both registers full under a stall: input side must stop
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(in_acc) && out_valid && !out_ready |-> !in_ready)
    else $error("request taken with pipeline full");

endmodule

bind piecewise_linear_activation_top pla_checker u_pla_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_chan.valid),
  .in_ready       (in_chan.ready),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .out_activation (out_chan.activation),
  .out_derivative (out_chan.derivative)
);
`default_nettype wire

// ----- tb/piecewise_linear_activation_top_tb.sv -----
`timescale 1ns / 1ps

module piecewise_linear_activation_top_tb;
  import pla_pkg::*;

  // unused mode codes, the block treats them as linear
  localparam logic [MODE_WIDTH-1:0] MODE_UNUSED_FIRST = 3'd5;
  localparam logic [MODE_WIDTH-1:0] MODE_UNUSED_LAST  = 3'd7;

  localparam int PROD_WIDTH = DATA_WIDTH + SLOPE_WIDTH;

  localparam logic signed [DATA_WIDTH-1:0] DATA_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] DATA_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam logic signed [DATA_WIDTH-1:0] ONE      = DATA_WIDTH'(1 << FRAC_BITS);

  localparam logic signed [SLOPE_WIDTH-1:0] SLOPE_MAX = {1'b0, {(SLOPE_WIDTH-1){1'b1}}};
  localparam logic signed [SLOPE_WIDTH-1:0] SLOPE_MIN = {1'b1, {(SLOPE_WIDTH-1){1'b0}}};

  localparam int RANDOM_SETTINGS  = 20;
  localparam int BATCHES          = 3;
  localparam int BATCH_SAMPLES    = 30;
  localparam int DRAIN_CYCLES     = 4;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT   = 2000;

  // one expected result, with the sample that caused it for reporting
  typedef struct {
    logic signed [DATA_WIDTH-1:0] sample;
    logic signed [DATA_WIDTH-1:0] activation;
    logic signed [DATA_WIDTH-1:0] derivative;
  } act_result_t;

  logic clk = 1'b0;
  logic rst_n;

  pla_in_if  in_chan ();
  pla_out_if out_chan ();

  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [APB_ADDR_WIDTH-1:0] paddr;
  logic [APB_DATA_WIDTH-1:0] pwdata;
  logic [APB_DATA_WIDTH-1:0] prdata;
  logic                      pready;

  piecewise_linear_activation_top u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow copy of the register file, only changed while the block is idle
  logic [MODE_WIDTH-1:0]         cur_mode;
  logic signed [DATA_WIDTH-1:0]  cur_clip_low;
  logic signed [DATA_WIDTH-1:0]  cur_clip_high;
  logic signed [SLOPE_WIDTH-1:0] cur_neg_slope;

  logic signed [DATA_WIDTH-1:0] pending_samples[$];
  act_result_t                  expected_results[$];

  // idling limits per side, changed between settings
  int unsigned send_gap_max  = 0;
  int unsigned rcv_stall_max = 0;

  // long receiver hold-off: requests raised by the stimulus, served by the monitor
  int unsigned long_hold_requests = 0;
  int unsigned long_hold_served   = 0;

  int unsigned samples_sent    = 0;
  int unsigned results_checked = 0;
  int unsigned mismatches      = 0;
  int unsigned settings_used   = 0;
  logic [7:0]  modes_seen      = '0;

  // clamp a wide value to the data range
  function automatic logic signed [DATA_WIDTH-1:0] saturate_data(
    logic signed [PROD_WIDTH-1:0] v
  );
    if (v > DATA_MAX) return DATA_MAX;
    if (v < DATA_MIN) return DATA_MIN;
    return v[DATA_WIDTH-1:0];
  endfunction

  // activation and derivative of one sample under the current registers
  function automatic act_result_t activate(logic signed [DATA_WIDTH-1:0] x);
    act_result_t                   r;
    logic signed [SLOPE_WIDTH-1:0] slope;
    logic signed [PROD_WIDTH-1:0]  prod;
    logic                          sloped;
    r.sample     = x;
    r.activation = x;
    r.derivative = ONE;
    slope        = '0;
    sloped       = 1'b0;
    case (cur_mode)
      MODE_CLIP: begin
        // limits in the wrong order still follow the same rules
        if (x > cur_clip_high) r.activation = cur_clip_high;
        else if (x < cur_clip_low) r.activation = cur_clip_low;
        r.derivative = (x < cur_clip_low || x > cur_clip_high) ? '0 : ONE;
      end
      MODE_RELU: begin
        if (x < 0) begin
          r.activation = '0;
          r.derivative = '0;
        end
      end
      MODE_LEAKY: begin
        slope  = LEAKY_SLOPE;
        sloped = 1'b1;
      end
      MODE_PRELU: begin
        slope  = cur_neg_slope;
        sloped = 1'b1;
      end
      default: ;
    endcase
    // zero counts as the positive side
    if (sloped && x < 0) begin
      prod         = x * slope;
      r.activation = saturate_data(prod >>> SLOPE_FRAC);
      r.derivative = saturate_data(slope >>> (SLOPE_FRAC - FRAC_BITS));
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // driver: offers pending samples, draws an idle gap after each request
  // ---------------------------------------------------------------------------
  logic        send_offer;
  int unsigned send_wait;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
      send_wait = 0;
    end else begin
      send_offer = in_chan.valid;
      if (in_chan.valid && in_chan.ready) begin
        // the request is taken: predict its result now, registers are stable
        expected_results.push_back(activate(in_chan.sample));
        modes_seen[cur_mode] = 1'b1;
        samples_sent++;
        send_offer = 1'b0;
        send_wait  = $urandom_range(0, send_gap_max);
      end
      if (!send_offer) begin
        if (send_wait != 0) begin
          send_wait--;
        end else if (pending_samples.size() != 0) begin
          in_chan.sample <= pending_samples.pop_front();
          send_offer = 1'b1;
        end
      end
      // one assignment per edge, so valid stays high across back-to-back requests
      in_chan.valid <= send_offer;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks each result against the oldest expectation, stalls at random
  // ---------------------------------------------------------------------------
  int unsigned rcv_wait;
  int unsigned long_hold_left;
  act_result_t got_expected;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      rcv_wait       = 0;
      long_hold_left = 0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t ns: result with nothing expected: activation %0d derivative %0d",
                   $time, out_chan.activation, out_chan.derivative);
          mismatches++;
        end else begin
          got_expected = expected_results.pop_front();
          if (out_chan.activation !== got_expected.activation) begin
            $display("%0t ns: activation of sample %0d: expected %0d, actual %0d",
                     $time, got_expected.sample, got_expected.activation,
                     out_chan.activation);
            mismatches++;
          end
          if (out_chan.derivative !== got_expected.derivative) begin
            $display("%0t ns: derivative of sample %0d: expected %0d, actual %0d",
                     $time, got_expected.sample, got_expected.derivative,
                     out_chan.derivative);
            mismatches++;
          end
          results_checked++;
        end
        rcv_wait = $urandom_range(0, rcv_stall_max);
      end else if (rcv_wait != 0) begin
        rcv_wait--;
      end
      // long hold-off lets the pipeline fill so the block has to stall its input
      if (long_hold_served != long_hold_requests) begin
        long_hold_served = long_hold_requests;
        long_hold_left   = LONG_HOLD_CYCLES;
      end else if (long_hold_left != 0) begin
        long_hold_left--;
      end
      out_chan.ready <= (rcv_wait == 0 && long_hold_left == 0);
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: cycles in a row with no request moving on either channel
  // ---------------------------------------------------------------------------
  int unsigned idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: no request moved for %0d cycles, %0d results outstanding",
               $time, idle_cycles, expected_results.size());
      $display("** piecewise_linear_activation_top: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // apb write: setup cycle, then access until pready
  task automatic cfg_write(reg_idx_t idx, logic [APB_DATA_WIDTH-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_WIDTH'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // writes all four registers and mirrors them; only called while idle
  task automatic apply_settings(
    logic [MODE_WIDTH-1:0]         m,
    logic signed [DATA_WIDTH-1:0]  lo,
    logic signed [DATA_WIDTH-1:0]  hi,
    logic signed [SLOPE_WIDTH-1:0] slope
  );
    cfg_write(REG_MODE, APB_DATA_WIDTH'(m));
    cfg_write(REG_CLIP_LOW, APB_DATA_WIDTH'(lo));
    cfg_write(REG_CLIP_HIGH, APB_DATA_WIDTH'(hi));
    cfg_write(REG_NEG_SLOPE, APB_DATA_WIDTH'(slope));
    cur_mode      = m;
    cur_clip_low  = lo;
    cur_clip_high = hi;
    cur_neg_slope = slope;
    settings_used++;
  endtask

  // waits until every pending sample is sent and every expected result is back, then a further quiet wait
  task automatic drain();
    do @(posedge clk);
    while (pending_samples.size() != 0 || in_chan.valid || expected_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // samples: extremes, values around zero and around the clip limits, full range
  function automatic logic signed [DATA_WIDTH-1:0] pick_sample();
    case ($urandom_range(0, 5))
      0: begin
        case ($urandom_range(0, 3))
          0: return DATA_MIN;
          1: return DATA_MAX;
          2: return '0;
          default: return -1;
        endcase
      end
      1: return DATA_WIDTH'(int'($urandom_range(0, 1024)) - 512);
      2: return cur_clip_low + DATA_WIDTH'(int'($urandom_range(0, 4)) - 2);
      3: return cur_clip_high + DATA_WIDTH'(int'($urandom_range(0, 4)) - 2);
      default: return DATA_WIDTH'($urandom());
    endcase
  endfunction

  function automatic logic signed [DATA_WIDTH-1:0] pick_limit();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 1) ? DATA_MAX : DATA_MIN;
      1: return DATA_WIDTH'(int'($urandom_range(0, 2048)) - 1024);
      default: return DATA_WIDTH'($urandom());
    endcase
  endfunction

  function automatic logic signed [SLOPE_WIDTH-1:0] pick_slope();
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 1) ? SLOPE_MAX : SLOPE_MIN;
      1: return SLOPE_WIDTH'($urandom_range(0, 1 << SLOPE_FRAC));        // 0 .. 1.0
      2: return -SLOPE_WIDTH'($urandom_range(0, 1 << SLOPE_FRAC));
      default: return SLOPE_WIDTH'($urandom());
    endcase
  endfunction

  // idle limit for one side: none, short or full
  function automatic int unsigned pick_idle();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 3;
      default: return 16;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  logic [MODE_WIDTH-1:0]         rnd_mode;
  logic signed [DATA_WIDTH-1:0]  rnd_low;
  logic signed [DATA_WIDTH-1:0]  rnd_high;
  logic signed [DATA_WIDTH-1:0]  rnd_swap;

  initial begin
    in_chan.valid  = 1'b0;
    in_chan.sample = '0;
    out_chan.ready = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    rst_n          = 1'b0;

    // registers after reset
    cur_mode      = MODE_RESET;
    cur_clip_low  = CLIP_LOW_RESET;
    cur_clip_high = CLIP_HIGH_RESET;
    cur_neg_slope = NEG_SLOPE_RESET;
    settings_used = 1;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // relu from reset: zero on the positive side, both extremes
    pending_samples.push_back('0);
    pending_samples.push_back(-1);
    pending_samples.push_back(1);
    pending_samples.push_back(DATA_MIN);
    pending_samples.push_back(DATA_MAX);
    drain();

    // leaky relu, fixed 0.01 slope
    apply_settings(MODE_LEAKY, CLIP_LOW_RESET, CLIP_HIGH_RESET, NEG_SLOPE_RESET);
    pending_samples.push_back(-1);
    pending_samples.push_back(DATA_MIN);
    pending_samples.push_back(-100);
    pending_samples.push_back('0);
    drain();

    // prelu at both slope extremes, the products with DATA_MIN saturate
    apply_settings(MODE_PRELU, CLIP_LOW_RESET, CLIP_HIGH_RESET, SLOPE_MAX);
    pending_samples.push_back(DATA_MIN);
    pending_samples.push_back(-1);
    drain();
    apply_settings(MODE_PRELU, CLIP_LOW_RESET, CLIP_HIGH_RESET, SLOPE_MIN);
    pending_samples.push_back(DATA_MIN);
    pending_samples.push_back(5);
    drain();

    // clipped linear on and just past the limits
    apply_settings(MODE_CLIP, -256, 256, NEG_SLOPE_RESET);
    pending_samples.push_back(-256);
    pending_samples.push_back(256);
    pending_samples.push_back(-257);
    pending_samples.push_back(257);
    drain();

    // limits in the wrong order
    apply_settings(MODE_CLIP, 100, -100, NEG_SLOPE_RESET);
    pending_samples.push_back('0);
    pending_samples.push_back(150);
    pending_samples.push_back(-150);
    drain();

    // linear and the unused codes that fall back to linear
    apply_settings(MODE_LINEAR, DATA_MIN, DATA_MAX, SLOPE_MAX);
    pending_samples.push_back(DATA_MAX);
    pending_samples.push_back(DATA_MIN);
    drain();
    apply_settings(MODE_UNUSED_LAST, DATA_MIN, DATA_MAX, SLOPE_MIN);
    pending_samples.push_back(-5);
    drain();
    apply_settings(MODE_UNUSED_FIRST, DATA_MAX, DATA_MIN, SLOPE_MIN);
    pending_samples.push_back(DATA_MIN);
    drain();

    // random settings, each with a few batches of samples
    for (int s = 0; s < RANDOM_SETTINGS; s++) begin
      if ($urandom_range(0, 5) == 0)
        rnd_mode = MODE_WIDTH'($urandom_range(MODE_UNUSED_FIRST, MODE_UNUSED_LAST));
      else
        rnd_mode = MODE_WIDTH'($urandom_range(MODE_LINEAR, MODE_PRELU));
      rnd_low  = pick_limit();
      rnd_high = pick_limit();
      // mostly ordered limits, now and then left reversed
      if (rnd_low > rnd_high && $urandom_range(0, 3) != 0) begin
        rnd_swap = rnd_low;
        rnd_low  = rnd_high;
        rnd_high = rnd_swap;
      end
      apply_settings(rnd_mode, rnd_low, rnd_high, pick_slope());
      send_gap_max  = pick_idle();
      rcv_stall_max = pick_idle();

      // once: receiver holds off while the sender keeps offering back to back
      if (s == 2) begin
        send_gap_max = 0;
        long_hold_requests++;
      end

      for (int b = 0; b < BATCHES; b++) begin
        repeat (BATCH_SAMPLES) pending_samples.push_back(pick_sample());
        // sometimes the sender pauses until every result is back
        if ($urandom_range(0, 1) != 0) drain();
      end
      drain();
    end

    drain();
    $display("run covered %0d samples and %0d checked results over %0d register settings",
             samples_sent, results_checked, settings_used);
    $display("modes exercised (bit per code): %b, mismatches: %0d", modes_seen, mismatches);
    if (mismatches == 0) begin
      $display("** piecewise_linear_activation_top: PASSED **");
    end else begin
      $display("** piecewise_linear_activation_top: FAILED **");
    end
    $finish;
  end

endmodule
